// ===== hw/rtl/ght_pkg.sv =====
// ----------------------------------------------------------------------------
// ght_pkg: shared types and constants for the generational handle table
// Sizes, opcode and status codes, and the structs passed between the
// execute logic and the top level.
// ----------------------------------------------------------------------------
package ght_pkg;

  localparam int SLOTS     = 256;
  localparam int IDX_W     = $clog2(SLOTS);      // slot address bits
  localparam int CNT_W     = $clog2(SLOTS + 1);  // counts 0..SLOTS
  localparam int TAG_W     = 16;
  localparam int HANDLE_W  = 32;
  localparam int HIDX_W    = 16;                  // index field of a handle

  localparam logic [TAG_W-1:0] TAG_MASK = 16'hffff;

  typedef enum logic [1:0] {
    MODE_ALLOC  = 2'd0,
    MODE_FREE   = 2'd1,
    MODE_LOOKUP = 2'd2
  } mode_t;

  typedef enum logic [1:0] {
    ST_OK      = 2'd0,
    ST_FULL    = 2'd1,
    ST_INVALID = 2'd2
  } status_t;

  // Architectural counters
  typedef struct packed {
    logic [CNT_W-1:0] free_count;
    logic [CNT_W-1:0] high_water;
    logic [TAG_W-1:0] tag_counter;
  } ght_state_t;

  // Memory write requests and next counter values for one transaction
  typedef struct packed {
    logic             tag_we;
    logic             tag_clr;     // free: slot tag returns to zero
    logic [IDX_W-1:0] tag_addr;
    logic [TAG_W-1:0] tag_wdata;
    logic             stk_we;
    logic [IDX_W-1:0] stk_addr;
    logic [IDX_W-1:0] stk_wdata;
    ght_state_t       state;
  } ght_upd_t;

  // One result item
  typedef struct packed {
    logic [1:0]          status;
    logic [HANDLE_W-1:0] handle_out;
    logic [IDX_W-1:0]    slot_index;
  } ght_res_t;

endpackage

// ===== hw/rtl/ght_exec.sv =====
// ----------------------------------------------------------------------------
// ght_exec: execute logic for one table transaction
// Validates handles, picks the slot to allocate, steps the tag counter and
// forms the result and the memory/counter updates. Purely combinational.
// ----------------------------------------------------------------------------
module ght_exec (
  input  logic [1:0]                    mode,
  input  logic [ght_pkg::HANDLE_W-1:0]  handle_in,
  input  logic                          tag_vld,
  input  logic [ght_pkg::TAG_W-1:0]     tag_rd,
  input  logic [ght_pkg::IDX_W-1:0]     stk_rd,
  input  ght_pkg::ght_state_t           cur,
  output ght_pkg::ght_res_t             res,
  output ght_pkg::ght_upd_t             upd
);
  import ght_pkg::*;

  logic [HIDX_W-1:0] h_idx;
  logic [TAG_W-1:0]  h_tag;
  logic [TAG_W-1:0]  stored_tag;
  logic              h_ok;
  logic [TAG_W-1:0]  tag_inc;
  logic [TAG_W-1:0]  tag_new;

  assign h_idx      = handle_in[HIDX_W-1:0];
  assign h_tag      = handle_in[HANDLE_W-1:HIDX_W] & TAG_MASK;
  assign stored_tag = tag_vld ? tag_rd : '0;
  assign h_ok       = (h_tag != '0)
                    && (h_idx < HIDX_W'(cur.high_water))
                    && (stored_tag == h_tag);

  // tag counter skips zero on wrap
  assign tag_inc = cur.tag_counter + TAG_W'(1);
  assign tag_new = (tag_inc == '0) ? TAG_W'(1) : tag_inc;

  always_comb begin
    res.status      = ST_INVALID;
    res.handle_out  = handle_in;
    res.slot_index  = '0;
    upd.tag_we      = 1'b0;
    upd.tag_clr     = 1'b0;
    upd.tag_addr    = h_idx[IDX_W-1:0];
    upd.tag_wdata   = tag_new;
    upd.stk_we      = 1'b0;
    upd.stk_addr    = cur.free_count[IDX_W-1:0];
    upd.stk_wdata   = h_idx[IDX_W-1:0];
    upd.state       = cur;
    case (mode)
      MODE_ALLOC: begin
        if (cur.free_count != '0) begin
          upd.tag_addr         = stk_rd;
          upd.state.free_count = cur.free_count - CNT_W'(1);
        end else if (cur.high_water < CNT_W'(SLOTS)) begin
          upd.tag_addr         = cur.high_water[IDX_W-1:0];
          upd.state.high_water = cur.high_water + CNT_W'(1);
        end
        if ((cur.free_count != '0) || (cur.high_water < CNT_W'(SLOTS))) begin
          upd.tag_we            = 1'b1;
          upd.state.tag_counter = tag_new;
          res.status            = ST_OK;
          res.handle_out        = {tag_new, HIDX_W'(upd.tag_addr)};
          res.slot_index        = upd.tag_addr;
        end else begin
          res.status     = ST_FULL;
          res.handle_out = '0;
        end
      end
      MODE_FREE: begin
        if (h_ok && (cur.free_count < CNT_W'(SLOTS))) begin
          upd.tag_clr          = 1'b1;
          upd.stk_we           = 1'b1;
          upd.state.free_count = cur.free_count + CNT_W'(1);
          res.status           = ST_OK;
          res.slot_index       = h_idx[IDX_W-1:0];
        end
      end
      MODE_LOOKUP: begin
        if (h_ok) begin
          res.status     = ST_OK;
          res.slot_index = h_idx[IDX_W-1:0];
        end
      end
      default: begin
        res.status = ST_INVALID;
      end
    endcase
  end

endmodule

// ===== hw/rtl/generational_slot_handle_table.sv =====
// ----------------------------------------------------------------------------
// generational_slot_handle_table: slot table issuing generation-tagged handles
// Allocate / free / look up 32-bit handles (tag 31:16, index 15:0) against
// a 256-entry tag store with a free-slot stack.
// ----------------------------------------------------------------------------
// The result is written into the output register on the commit edge; a result still
//   waiting in the output register holds the commit off until it is taken.
// A new transaction is accepted only after the previous one commits; the tag
//   store and free stack are read on the accept edge and written on the
//   commit edge that follows.
// Reset (rst_n low, synchronous): counters cleared, per-slot valid bits
//   cleared so every tag reads as zero; no clearing pass is needed.
// A finished result waits in the output register while the next
// transaction is taken in.
module generational_slot_handle_table (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          in_valid,
  output logic                          in_ready,
  input  logic [1:0]                    in_mode,
  input  logic [ght_pkg::HANDLE_W-1:0]  in_handle_in,
  output logic                          out_valid,
  input  logic                          out_ready,
  output logic [1:0]                    out_status,
  output logic [ght_pkg::HANDLE_W-1:0]  out_handle_out,
  output logic [ght_pkg::IDX_W-1:0]     out_slot_index
);
  import ght_pkg::*;

  // Storage: tag store with per-entry valid bits, free stack (no reset)
  logic [TAG_W-1:0] tag_mem [SLOTS];
  logic [SLOTS-1:0] tag_vld_r;
  logic [IDX_W-1:0] stk_mem [SLOTS];

  // Control and counters
  logic       busy_r, busy_nxt;
  logic       out_valid_r, out_valid_nxt;
  ght_state_t st_r;

  // Captured transaction and registered memory read data
  logic [1:0]          mode_r;
  logic [HANDLE_W-1:0] handle_r;
  logic [TAG_W-1:0]    tag_rd_r;
  logic                tag_vld_rd_r;
  logic [IDX_W-1:0]    stk_rd_r;

  ght_res_t res, res_r;
  ght_upd_t upd;

  logic in_acc;
  logic commit;
  logic [CNT_W-1:0] stk_top;

  assign in_ready  = !busy_r;
  assign in_acc    = in_valid && in_ready;
  // finish the transaction once the output register can take its result
  assign commit    = busy_r && (!out_valid_r || out_ready);
  assign stk_top   = st_r.free_count - CNT_W'(1);

  always_comb begin
    busy_nxt      = busy_r;
    out_valid_nxt = out_valid_r;
    if (out_valid_r && out_ready) out_valid_nxt = 1'b0;
    if (commit) begin
      busy_nxt      = 1'b0;
      out_valid_nxt = 1'b1;
    end
    if (in_acc) busy_nxt = 1'b1;
  end

  // Read phase: capture the transaction and read both memories
  always_ff @(posedge clk) begin
    if (in_acc) begin
      mode_r       <= in_mode;
      handle_r     <= in_handle_in;
      tag_rd_r     <= tag_mem[in_handle_in[IDX_W-1:0]];
      tag_vld_rd_r <= tag_vld_r[in_handle_in[IDX_W-1:0]];
      stk_rd_r     <= stk_mem[stk_top[IDX_W-1:0]];
    end
  end

  ght_exec u_exec (
    .mode      (mode_r),
    .handle_in (handle_r),
    .tag_vld   (tag_vld_rd_r),
    .tag_rd    (tag_rd_r),
    .stk_rd    (stk_rd_r),
    .cur       (st_r),
    .res       (res),
    .upd       (upd)
  );

  // Write phase: memory updates
  always_ff @(posedge clk) begin
    if (commit && upd.tag_we) begin
      tag_mem[upd.tag_addr] <= upd.tag_wdata;
    end
    if (commit && upd.stk_we) begin
      stk_mem[upd.stk_addr] <= upd.stk_wdata;
    end
    if (commit) begin
      res_r <= res;
    end
  end

  // Control state, counters and tag valid bits
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r      <= 1'b0;
      out_valid_r <= 1'b0;
      st_r        <= '0;
      tag_vld_r   <= '0;
    end else begin
      busy_r      <= busy_nxt;
      out_valid_r <= out_valid_nxt;
      if (commit) begin
        st_r <= upd.state;
        if (upd.tag_we)  tag_vld_r[upd.tag_addr] <= 1'b1;
        if (upd.tag_clr) tag_vld_r[upd.tag_addr] <= 1'b0;
      end
    end
  end

  assign out_valid      = out_valid_r;
  assign out_status     = res_r.status;
  assign out_handle_out = res_r.handle_out;
  assign out_slot_index = res_r.slot_index;

endmodule
